// ===== src/fgb_pkg.sv =====
package fgb_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 13;

	localparam int DEF_MAX_GRID_ROWS = 8;
	localparam int DEF_MAX_GRID_COLS = 8;
	localparam int DEF_MAX_SLOTS     = 8;
	localparam int DEF_COORD_BITS    = 12;

	localparam int SCORE_W = 10;
	// 3277 / 2^16 is just above 1/20 and close enough to give floor(d / 20) for d < 1024.
	localparam logic [21:0] RECIP_20 = 22'd3277;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DRAIN  = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS    = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_START_ROW    = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOTS        = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_AGE_LIMIT    = 4'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CELL,
		ST_COORD,
		ST_FILL,
		ST_SCAN,
		ST_REPL,
		ST_DR_CHK,
		ST_DR_ENT,
		ST_NX_CHK
	} state_t;

	// Score is age plus (strength - threshold) / 20, truncated towards zero.
	function automatic logic signed [SCORE_W-1:0] fgb_score(input logic [7:0] age,
			input logic [9:0] strength, input logic [7:0] thr);
		logic signed [11:0] diff;
		logic [9:0] mag;
		logic [21:0] prod;
		logic [5:0] quo;
		diff = $signed({2'b00, strength}) - $signed({4'b0000, thr});
		mag = diff[11] ? 10'(-diff) : 10'(diff);
		prod = 22'(mag) * RECIP_20;
		quo = prod[21:16];
		if (diff[11]) begin
			return $signed({2'b00, age}) - $signed({4'b0000, quo});
		end
		return $signed({2'b00, age}) + $signed({4'b0000, quo});
	endfunction

endpackage

// ===== src/feature_grid_bucketing.sv =====
// Grid bucketing of feature points. An item is taken when start is high and busy is low;
// a drain item answers with one result on the out ports for a single cycle, marked by done,
// and the receiver cannot stall it. An insert finds the cell row and column with a
// one-bit-per-cycle divider pair of width W (14 at the default coordinate width), then
// scans the kept entries if the bucket is full; the first insert after a register write
// first runs the divider pair once more to work out the cell sizes. A drain steps over
// each empty bucket in the fill-count memory. A clear is handled without leaving idle.
// The slot store and fill counts live in single-port-write RAMs with registered reads;
// registers can be written at any time the block is idle.
module feature_grid_bucketing
	import fgb_pkg::*;
#(
	parameter int MAX_GRID_ROWS = DEF_MAX_GRID_ROWS,
	parameter int MAX_GRID_COLS = DEF_MAX_GRID_COLS,
	parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
	parameter int COORD_BITS    = DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             kind,
	input  logic [COORD_BITS-1:0]  pos_x,
	input  logic [COORD_BITS-1:0]  pos_y,
	input  logic [7:0]             feature_age,
	input  logic [9:0]             feature_strength,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   done,
	output logic                   valid_res,
	output logic [COORD_BITS-1:0]  out_x,
	output logic [COORD_BITS-1:0]  out_y,
	output logic [7:0]             out_age,
	output logic [9:0]             out_strength,
	output logic                   last
);

	localparam int NB = MAX_GRID_ROWS * MAX_GRID_COLS;
	localparam int BW = NB > 1 ? $clog2(NB) : 1;
	localparam int SW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int NS = NB * MAX_SLOTS;
	localparam int AW = NS > 1 ? $clog2(NS) : 1;
	localparam int EW = 2 * COORD_BITS + 18;
	localparam int DW = COORD_BITS > 14 ? COORD_BITS : 14;
	localparam logic [BW-1:0] B_LAST = BW'(NB - 1);

	function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b, input logic [SW-1:0] s);
		return AW'(b) * AW'(MAX_SLOTS) + AW'(s);
	endfunction

	state_t state_q, state_d;

	logic [12:0] width_q, height_q;
	logic [3:0]  rows_q, cols_q, start_row_q, slots_q;
	logic [7:0]  thr_q, age_limit_q;
	logic        sizes_ok_q;

	logic [COORD_BITS-1:0] x_q, y_q;
	logic [7:0]            age_q;
	logic [9:0]            str_q;
	logic [DW-1:0]         ch_q, cw_q;
	logic [BW-1:0]         bkt_q;
	logic [CW-1:0]         cap_q, n_q, idx_q;
	logic                  scan_vld_s1;
	logic [SW-1:0]         scan_idx_s1;
	logic signed [SCORE_W-1:0] min_s_q;
	logic [SW-1:0]         min_i_q;
	logic [BW-1:0]         scan_b_q, drain_b_q;
	logic [SW-1:0]         scan_s_q, drain_s_q;
	logic [NB-1:0]         fill_vld_q;
	logic                  fill_vld_s1;
	logic                  done_q;

	logic          accept;
	logic          div_go, div_done, done_r, done_c;
	logic [DW-1:0] dvd_r, dvs_r, dvd_c, dvs_c, quo_r, quo_c;
	logic [DW-1:0] ih_dw, iw_dw, rows_dw, cols_dw, r_dw, c_dw;
	logic [BW-1:0] bkt_c;
	logic          row_ok;
	logic [CW-1:0] cap_c, fill_val, next_s;

	logic          fill_we;
	logic [BW-1:0] fill_raddr;
	logic [CW-1:0] fill_wdata, fill_rdata;
	logic          slot_we;
	logic [AW-1:0] slot_waddr, slot_raddr;
	logic [EW-1:0] slot_wdata, slot_rdata;
	logic signed [SCORE_W-1:0] score_new, score_rd;
	logic          fin, fin_empty, fin_last, do_clear;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign div_done = done_r && done_c;

	assign ih_dw = (height_q == '0) ? DW'(1) : DW'(height_q);
	assign iw_dw = (width_q == '0) ? DW'(1) : DW'(width_q);
	assign rows_dw = (rows_q == '0) ? DW'(1) :
		(DW'(rows_q) > DW'(MAX_GRID_ROWS)) ? DW'(MAX_GRID_ROWS) : DW'(rows_q);
	assign cols_dw = (cols_q == '0) ? DW'(1) :
		(DW'(cols_q) > DW'(MAX_GRID_COLS)) ? DW'(MAX_GRID_COLS) : DW'(cols_q);
	assign r_dw = (quo_r > rows_dw - DW'(1)) ? rows_dw - DW'(1) : quo_r;
	assign c_dw = (quo_c > cols_dw - DW'(1)) ? cols_dw - DW'(1) : quo_c;
	assign bkt_c = BW'(r_dw) * BW'(MAX_GRID_COLS) + BW'(c_dw);
	assign row_ok = (r_dw >= DW'(start_row_q));
	assign cap_c = (int'(slots_q) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(slots_q);

	assign fill_val = fill_vld_s1 ? fill_rdata : '0;
	assign next_s = CW'(scan_s_q) + CW'(1);
	assign slot_wdata = {x_q, y_q, age_q, str_q};
	assign score_new = fgb_score(age_q, str_q, thr_q);
	assign score_rd = fgb_score(slot_rdata[17:10], slot_rdata[9:0], thr_q);

	fgb_div #(.W(DW)) u_div_row (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(dvd_r), .divisor(dvs_r),
		.done(done_r), .quotient(quo_r)
	);

	fgb_div #(.W(DW)) u_div_col (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(dvd_c), .divisor(dvs_c),
		.done(done_c), .quotient(quo_c)
	);

	fgb_ram #(.WIDTH(CW), .DEPTH(NB)) u_fill_ram (
		.clk(clk), .we(fill_we), .waddr(bkt_q), .wdata(fill_wdata),
		.raddr(fill_raddr), .rdata(fill_rdata)
	);

	fgb_ram #(.WIDTH(EW), .DEPTH(NS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	always_comb begin
		state_d = state_q;
		div_go = 1'b0;
		dvd_r = DW'(y_q);
		dvs_r = ch_q;
		dvd_c = DW'(x_q);
		dvs_c = cw_q;
		fill_raddr = drain_b_q;
		fill_we = 1'b0;
		fill_wdata = fill_val + CW'(1);
		slot_we = 1'b0;
		slot_waddr = slot_addr(bkt_q, SW'(fill_val));
		slot_raddr = slot_addr(bkt_q, SW'(idx_q));
		fin = 1'b0;
		fin_empty = 1'b0;
		fin_last = 1'b0;
		do_clear = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_INSERT: begin
							if (feature_age < age_limit_q) begin
								state_d = ST_PREP;
							end
						end
						KIND_DRAIN: begin
							fill_raddr = drain_b_q;
							state_d = ST_DR_CHK;
						end
						KIND_CLEAR: do_clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_PREP: begin
				div_go = 1'b1;
				if (sizes_ok_q) begin
					state_d = ST_COORD;
				end else begin
					dvd_r = ih_dw + rows_dw - DW'(1);
					dvs_r = rows_dw;
					dvd_c = iw_dw + cols_dw - DW'(1);
					dvs_c = cols_dw;
					state_d = ST_CELL;
				end
			end
			ST_CELL: begin
				if (div_done) begin
					div_go = 1'b1;
					dvs_r = quo_r;
					dvs_c = quo_c;
					state_d = ST_COORD;
				end
			end
			ST_COORD: begin
				if (div_done) begin
					fill_raddr = bkt_c;
					state_d = (row_ok && cap_c != '0) ? ST_FILL : ST_IDLE;
				end
			end
			ST_FILL: begin
				if (fill_val < cap_q) begin
					slot_we = 1'b1;
					fill_we = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == n_q && !scan_vld_s1) begin
					state_d = ST_REPL;
				end
			end
			ST_REPL: begin
				if (score_new > min_s_q) begin
					slot_we = 1'b1;
					slot_waddr = slot_addr(bkt_q, min_i_q);
				end
				state_d = ST_IDLE;
			end
			ST_DR_CHK: begin
				slot_raddr = slot_addr(scan_b_q, scan_s_q);
				if (CW'(scan_s_q) < fill_val) begin
					state_d = ST_DR_ENT;
				end else if (scan_b_q == B_LAST) begin
					fin = 1'b1;
					fin_empty = 1'b1;
					do_clear = 1'b1;
					state_d = ST_IDLE;
				end else begin
					fill_raddr = BW'(scan_b_q + BW'(1));
				end
			end
			ST_DR_ENT: begin
				if (next_s < n_q) begin
					fin = 1'b1;
					state_d = ST_IDLE;
				end else if (scan_b_q == B_LAST) begin
					fin = 1'b1;
					fin_last = 1'b1;
					do_clear = 1'b1;
					state_d = ST_IDLE;
				end else begin
					fill_raddr = BW'(scan_b_q + BW'(1));
					state_d = ST_NX_CHK;
				end
			end
			ST_NX_CHK: begin
				if (fill_val != '0) begin
					fin = 1'b1;
					state_d = ST_IDLE;
				end else if (scan_b_q == B_LAST) begin
					fin = 1'b1;
					fin_last = 1'b1;
					do_clear = 1'b1;
					state_d = ST_IDLE;
				end else begin
					fill_raddr = BW'(scan_b_q + BW'(1));
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd640;
			height_q <= 13'd480;
			rows_q <= 4'd8;
			cols_q <= 4'd8;
			start_row_q <= 4'd0;
			slots_q <= 4'd4;
			thr_q <= 8'd20;
			age_limit_q <= 8'd10;
			sizes_ok_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			sizes_ok_q <= 1'b0;
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_GRID_ROWS:    rows_q <= cfg_data[3:0];
				REG_GRID_COLS:    cols_q <= cfg_data[3:0];
				REG_START_ROW:    start_row_q <= cfg_data[3:0];
				REG_SLOTS:        slots_q <= cfg_data[3:0];
				REG_THRESHOLD:    thr_q <= cfg_data[7:0];
				REG_AGE_LIMIT:    age_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end else if (state_q == ST_CELL && div_done) begin
			sizes_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			fill_vld_q <= '0;
			fill_vld_s1 <= 1'b0;
			scan_vld_s1 <= 1'b0;
			drain_b_q <= '0;
			drain_s_q <= '0;
		end else begin
			done_q <= fin;
			fill_vld_s1 <= fill_vld_q[fill_raddr];
			scan_vld_s1 <= (state_q == ST_SCAN) && (idx_q < n_q);
			if (state_q == ST_DR_ENT && next_s < n_q) begin
				drain_b_q <= scan_b_q;
				drain_s_q <= SW'(next_s);
			end
			if (state_q == ST_NX_CHK && fill_val != '0) begin
				drain_b_q <= scan_b_q;
				drain_s_q <= '0;
			end
			if (fill_we) begin
				fill_vld_q[bkt_q] <= 1'b1;
			end
			// A clear also closes the drain once its last item is out.
			if (do_clear) begin
				fill_vld_q <= '0;
				drain_b_q <= '0;
				drain_s_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= pos_x;
				y_q <= pos_y;
				age_q <= feature_age;
				str_q <= feature_strength;
				scan_b_q <= drain_b_q;
				scan_s_q <= drain_s_q;
			end
			ST_CELL: begin
				if (div_done) begin
					ch_q <= quo_r;
					cw_q <= quo_c;
				end
			end
			ST_COORD: begin
				bkt_q <= bkt_c;
				cap_q <= row_ok ? cap_c : '0;
			end
			ST_FILL: begin
				n_q <= fill_val;
				idx_q <= '0;
			end
			ST_SCAN: begin
				if (idx_q < n_q) begin
					idx_q <= idx_q + CW'(1);
				end
				scan_idx_s1 <= SW'(idx_q);
				if (scan_vld_s1 && (scan_idx_s1 == '0 || score_rd < min_s_q)) begin
					min_s_q <= score_rd;
					min_i_q <= scan_idx_s1;
				end
			end
			ST_DR_CHK: begin
				if (CW'(scan_s_q) < fill_val) begin
					n_q <= fill_val;
				end else if (scan_b_q == B_LAST) begin
					valid_res <= 1'b0;
					out_x <= '0;
					out_y <= '0;
					out_age <= '0;
					out_strength <= '0;
					last <= 1'b0;
				end else begin
					scan_b_q <= BW'(scan_b_q + BW'(1));
					scan_s_q <= '0;
				end
			end
			ST_DR_ENT: begin
				valid_res <= 1'b1;
				out_x <= slot_rdata[EW-1 -: COORD_BITS];
				out_y <= slot_rdata[EW-1-COORD_BITS -: COORD_BITS];
				out_age <= slot_rdata[17:10];
				out_strength <= slot_rdata[9:0];
				last <= fin_last;
				if (!(next_s < n_q) && scan_b_q != B_LAST) begin
					scan_b_q <= BW'(scan_b_q + BW'(1));
				end
			end
			ST_NX_CHK: begin
				if (fin_last) begin
					last <= 1'b1;
				end else if (fill_val == '0) begin
					scan_b_q <= BW'(scan_b_q + BW'(1));
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while an item is still in work");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |-> !last && out_x == '0 && out_y == '0 && out_age == '0
			&& out_strength == '0)
		else $error("empty drain result carries data");

	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> drain_b_q == '0 && drain_s_q == '0 && fill_vld_q == '0)
		else $error("store not cleared after the last drained item");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> fill_wdata != '0 && fill_wdata <= cap_q)
		else $error("fill count written above the bucket capacity");
`endif

endmodule

// ===== src/fgb_ram.sv =====
module fgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/fgb_div.sv =====
// Restoring divider, one quotient bit per cycle; the divisor must be non-zero.
module fgb_div #(
	parameter int W = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNTW = $clog2(W + 1);

	logic [CNTW-1:0] cnt_q;
	logic            active_q;
	logic            done_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    dvs_q;
	logic [W:0]      trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			active_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNTW'(W);
				active_q <= 1'b1;
			end else if (active_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (active_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== dv/feature_grid_bucketing_test.sv =====
module feature_grid_bucketing_test;
	import fgb_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int NUM_BUCKETS = DEF_MAX_GRID_ROWS * DEF_MAX_GRID_COLS;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic        ok;
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  age;
		logic [9:0]  strength;
		logic        last;
	} feature_out_t;

	typedef struct {
		logic [1:0]   kind;
		logic [11:0]  x;
		logic [11:0]  y;
		logic [7:0]   age;
		logic [9:0]   strength;
		bit           typed;
		feature_out_t want;
	} item_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = KIND_INSERT;
	logic [11:0] pos_x = '0;
	logic [11:0] pos_y = '0;
	logic [7:0] feature_age = '0;
	logic [9:0] feature_strength = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic done, valid_res, last;
	logic [11:0] out_x, out_y;
	logic [7:0] out_age;
	logic [9:0] out_strength;

	feature_grid_bucketing u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .feature_age(feature_age),
		.feature_strength(feature_strength), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .valid_res(valid_res),
		.out_x(out_x), .out_y(out_y), .out_age(out_age), .out_strength(out_strength),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Shadow copy of the grid: kept features, fill counts, drain position and registers.
	logic [11:0] kept_x [NUM_BUCKETS][DEF_MAX_SLOTS];
	logic [11:0] kept_y [NUM_BUCKETS][DEF_MAX_SLOTS];
	logic [7:0]  kept_age [NUM_BUCKETS][DEF_MAX_SLOTS];
	logic [9:0]  kept_strength [NUM_BUCKETS][DEF_MAX_SLOTS];
	int fill [NUM_BUCKETS];
	int drain_bkt, drain_pos;
	int img_w = 640, img_h = 480, rows_cfg = 8, cols_cfg = 8, first_row = 0;
	int slots_cfg = 4, threshold = 20, age_limit = 10;

	feature_out_t pending_features [$];
	item_row_t directed_rows [$];
	int mismatches = 0;
	bit idle_gaps = 1'b1;
	int stall_cycles = 0;

	function automatic int clamp_int(input int v, input int lo, input int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Division in SystemVerilog truncates towards zero, as the score requires.
	function automatic int feature_score(input int a, input int s);
		return a + (s - threshold) / 20;
	endfunction

	function automatic bit find_kept(inout int b, inout int s);
		while (b < NUM_BUCKETS) begin
			if (s < fill[b] && s < DEF_MAX_SLOTS) return 1'b1;
			b++;
			s = 0;
		end
		return 1'b0;
	endfunction

	function automatic void clear_grid();
		foreach (fill[i]) fill[i] = 0;
		drain_bkt = 0;
		drain_pos = 0;
	endfunction

	function automatic void place_feature(input int x, input int y, input int a, input int s);
		int nrows, ncols, ch, cw, r, c, cap, b, n, min_i, min_s, t;
		nrows = clamp_int(rows_cfg, 1, DEF_MAX_GRID_ROWS);
		ncols = clamp_int(cols_cfg, 1, DEF_MAX_GRID_COLS);
		ch = ((img_h == 0 ? 1 : img_h) + nrows - 1) / nrows;
		cw = ((img_w == 0 ? 1 : img_w) + ncols - 1) / ncols;
		r = y / ch;
		c = x / cw;
		if (r > nrows - 1) r = nrows - 1;
		if (c > ncols - 1) c = ncols - 1;
		cap = (r >= first_row) ? clamp_int(slots_cfg, 0, DEF_MAX_SLOTS) : 0;
		if (cap == 0 || a >= age_limit) return;
		b = r * DEF_MAX_GRID_COLS + c;
		n = fill[b] > DEF_MAX_SLOTS ? DEF_MAX_SLOTS : fill[b];
		if (n < cap) begin
			min_i = n;
			fill[b] = n + 1;
		end else begin
			min_i = 0;
			min_s = feature_score(kept_age[b][0], kept_strength[b][0]);
			for (int i = 1; i < n; i++) begin
				t = feature_score(kept_age[b][i], kept_strength[b][i]);
				if (t < min_s) begin
					min_s = t;
					min_i = i;
				end
			end
			if (feature_score(a, s) <= min_s) return;
		end
		kept_x[b][min_i] = x;
		kept_y[b][min_i] = y;
		kept_age[b][min_i] = a;
		kept_strength[b][min_i] = s;
	endfunction

	function automatic bit predict_item(input item_row_t it, output feature_out_t res);
		int b, s, nb, ns;
		res = '0;
		case (it.kind)
			KIND_INSERT: begin
				place_feature(it.x, it.y, it.age, it.strength);
				return 1'b0;
			end
			KIND_CLEAR: begin
				clear_grid();
				return 1'b0;
			end
			KIND_DRAIN: begin
				b = drain_bkt;
				s = drain_pos;
				if (!find_kept(b, s)) begin
					clear_grid();
					return 1'b1;
				end
				res.ok = 1'b1;
				res.x = kept_x[b][s];
				res.y = kept_y[b][s];
				res.age = kept_age[b][s];
				res.strength = kept_strength[b][s];
				nb = b;
				ns = s + 1;
				if (find_kept(nb, ns)) begin
					drain_bkt = nb;
					drain_pos = ns;
				end else begin
					res.last = 1'b1;
					clear_grid();
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int features_kept();
		int total;
		total = 0;
		foreach (fill[i]) total += fill[i] > DEF_MAX_SLOTS ? DEF_MAX_SLOTS : fill[i];
		return total;
	endfunction

	task automatic send_item(input item_row_t it);
		int gap;
		feature_out_t res;
		gap = idle_gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= it.kind;
		pos_x <= it.x;
		pos_y <= it.y;
		feature_age <= it.age;
		feature_strength <= it.strength;
		do @(posedge clk); while (busy);
		if (predict_item(it, res)) pending_features.push_back(it.typed ? it.want : res);
	endtask

	task automatic wait_for_idle();
		start <= 1'b0;
		while (pending_features.size() != 0) @(posedge clk);
		// An insert leaves no result behind, so give the last one time to finish.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_registers(input int vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i;
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (i)
				REG_IMAGE_WIDTH:  img_w = vals[i] & 13'h1fff;
				REG_IMAGE_HEIGHT: img_h = vals[i] & 13'h1fff;
				REG_GRID_ROWS:    rows_cfg = vals[i] & 4'hf;
				REG_GRID_COLS:    cols_cfg = vals[i] & 4'hf;
				REG_START_ROW:    first_row = vals[i] & 4'hf;
				REG_SLOTS:        slots_cfg = vals[i] & 4'hf;
				REG_THRESHOLD:    threshold = vals[i] & 8'hff;
				REG_AGE_LIMIT:    age_limit = vals[i] & 8'hff;
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_row(input logic [1:0] k, input int x, input int y, input int a,
			input int s, input bit typed, input feature_out_t want);
		item_row_t it;
		it.kind = k;
		it.x = x;
		it.y = y;
		it.age = a;
		it.strength = s;
		it.typed = typed;
		it.want = want;
		directed_rows.push_back(it);
	endfunction

	function automatic item_row_t random_insert();
		item_row_t it;
		int w, h;
		w = img_w == 0 ? 1 : img_w;
		h = img_h == 0 ? 1 : img_h;
		it.kind = KIND_INSERT;
		it.x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, w - 1);
		it.y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, h - 1);
		it.age = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, age_limit);
		it.strength = $urandom_range(0, 1023);
		it.typed = 1'b0;
		it.want = '0;
		return it;
	endfunction

	function automatic int pick_reg(input int maxv, input int lo, input int hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return maxv;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	always @(posedge clk) begin
		feature_out_t got, want;
		if (arst_n && done) begin
			got = {valid_res, out_x, out_y, out_age, out_strength, last};
			if (pending_features.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_features.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: valid %b/%b x %0d/%0d y %0d/%0d age %0d/%0d str %0d/%0d last %b/%b (exp/got)",
							want.ok, got.ok, want.x, got.x, want.y, got.y, want.age, got.age,
							want.strength, got.strength, want.last, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		feature_out_t none, f;
		int vals [8];
		int burst;
		item_row_t it;
		none = '0;
		clear_grid();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default grid of 8 by 8 cells, each 80 by 60 pixels, four slots per bucket.
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b1, none);
		add_row(KIND_INSERT, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_INSERT, 4095, 4095, 9, 1023, 1'b0, none);
		add_row(KIND_INSERT, 100, 100, 10, 500, 1'b0, none);
		add_row(KIND_IGNORED, 200, 200, 1, 1, 1'b0, none);
		f = '{1'b1, 12'd0, 12'd0, 8'd0, 10'd0, 1'b0};
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b1, f);
		f = '{1'b1, 12'd4095, 12'd4095, 8'd9, 10'd1023, 1'b1};
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b1, f);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b1, none);
		for (int i = 1; i <= 4; i++) add_row(KIND_INSERT, i, i, i, 20, 1'b0, none);
		add_row(KIND_INSERT, 5, 5, 1, 40, 1'b0, none);
		add_row(KIND_INSERT, 6, 6, 1, 20, 1'b0, none);
		add_row(KIND_INSERT, 7, 7, 0, 1, 1'b0, none);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_INSERT, 8, 8, 9, 1023, 1'b0, none);
		add_row(KIND_INSERT, 500, 400, 2, 0, 1'b0, none);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_CLEAR, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b1, none);
		add_row(KIND_INSERT, 10, 10, 1, 5, 1'b0, none);
		add_row(KIND_DRAIN, 0, 0, 0, 0, 1'b0, none);
		foreach (directed_rows[i]) send_item(directed_rows[i]);

		for (int phase = 0; phase < 8; phase++) begin
			wait_for_idle();
			case (phase)
				0: vals = '{4096, 4096, 8, 8, 0, 8, 0, 255};
				1: vals = '{1, 1, 1, 1, 0, 1, 255, 0};
				2: vals = '{8191, 8191, 15, 15, 15, 15, 255, 255};
				3: vals = '{0, 0, 0, 0, 3, 0, 128, 200};
				4: vals = '{320, 240, 4, 4, 1, 2, 20, 30};
				default: vals = '{pick_reg(8191, 1, 4096), pick_reg(8191, 1, 4096),
					pick_reg(15, 1, 8), pick_reg(15, 1, 8), pick_reg(15, 0, 3),
					pick_reg(15, 1, 8), pick_reg(255, 0, 255), pick_reg(255, 1, 255)};
			endcase
			if (phase == 3) vals[3] = 8;
			write_registers(vals);
			idle_gaps = (phase % 3) != 1;
			for (int n = 0; n < 220; ) begin
				burst = $urandom_range(1, 30);
				for (int j = 0; j < burst; j++, n++) send_item(random_insert());
				case ($urandom_range(0, 9))
					0: begin
						it = random_insert();
						it.kind = KIND_CLEAR;
						send_item(it);
						n++;
					end
					1: begin
						it = random_insert();
						it.kind = KIND_IGNORED;
						send_item(it);
					end
					2, 3: begin
						// Partial drain, so later inserts land behind and ahead of it.
						it = random_insert();
						it.kind = KIND_DRAIN;
						repeat ($urandom_range(1, 6)) begin
							send_item(it);
							n++;
						end
					end
					default: begin
						it = random_insert();
						it.kind = KIND_DRAIN;
						burst = features_kept() + 1;
						repeat (burst) begin
							send_item(it);
							n++;
						end
					end
				endcase
			end
		end

		start <= 1'b0;
		while (pending_features.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
